FILE: rtl/nonpreemptive_ready_queue_scheduler_top_assert.svh
`ifndef NONPREEMPTIVE_READY_QUEUE_SCHEDULER_TOP_ASSERT_SVH
`define NONPREEMPTIVE_READY_QUEUE_SCHEDULER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define NRQS_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define NRQS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/nrqs_pkg.sv
package nrqs_pkg;

	localparam int QUEUE_DEPTH_DEF = 64;
	localparam int ID_W            = 16;
	localparam int KEY_W           = 16;
	localparam int ENTRY_W         = ID_W + KEY_W;
	localparam int OCC_W           = 7;
	localparam int MODE_W          = 2;

	// scheduling modes that pick the smallest key
	localparam logic [MODE_W-1:0] MODE_SJF  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PRIO = 2'd2;

	localparam logic FUNC_INSERT = 1'b0;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_DONE
	} state_t;

endpackage

FILE: rtl/nrqs_ram.sv
module nrqs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/nonpreemptive_ready_queue_scheduler_top.sv
// Non-preemptive ready queue: holds up to QUEUE_DEPTH jobs (16-bit id, 16-bit sort key) in
// arrival order in a single-port-write, single-port-read RAM. An item with func 0 appends a
// job (status full when the queue is full); an item with func 1 removes a job (status empty
// when there is none). sched_mode 0 (and 3) takes the oldest job, modes 1 and 2 take the
// smallest key with the oldest winning ties; the hole is closed by moving later entries
// down one slot. One item is in flight at a time. A dispatch goes through the single RAM
// read port, which walks the queue once for the minimum search in min-key modes and once
// for the close-up. A finished result sits in the output register, so the next item is
// taken while it waits.
module nonpreemptive_ready_queue_scheduler_top #(
	parameter int QUEUE_DEPTH = nrqs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // job_id[15:0], sort_key[31:16]
	input  logic [0:0]  s_tuser,   // func[0]
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // out_job_id[15:0], out_key[31:16], occupancy[38:32]
	output logic [1:0]  m_tuser,   // status[1:0]
	// sched_mode register
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata
);

	localparam int AW    = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	nrqs_pkg::state_t  state_q, state_d;
	nrqs_pkg::status_t status_q;

	logic [nrqs_pkg::MODE_W-1:0] mode_q;
	logic [CNT_W-1:0]            count_q;

	// scan and shift pointer: address whose data is on the ram output
	logic [CNT_W-1:0] ptr_q;
	logic [CNT_W-1:0] last_q;
	logic [CNT_W-1:0] best_ptr_q;
	logic [nrqs_pkg::ID_W-1:0]  best_id_q;
	logic [nrqs_pkg::KEY_W-1:0] best_key_q;

	logic        m_valid_q;
	logic [39:0] m_tdata_q;
	logic [1:0]  m_tuser_q;

	// ram ports
	logic                        ram_we;
	logic [CNT_W-1:0]            ram_waddr;
	logic [nrqs_pkg::ENTRY_W-1:0] ram_wdata;
	logic [CNT_W-1:0]            ram_raddr;
	logic [nrqs_pkg::ENTRY_W-1:0] ram_rdata;

	logic                       acc;
	logic                       in_func;
	logic [nrqs_pkg::ID_W-1:0]  in_id;
	logic [nrqs_pkg::KEY_W-1:0] in_key;
	logic                       full;
	logic                       empty;
	logic                       min_mode;
	logic                       out_free;
	logic [CNT_W-1:0]           tail;

	logic [nrqs_pkg::ID_W-1:0]  rd_id;
	logic [nrqs_pkg::KEY_W-1:0] rd_key;
	logic                       take;
	logic                       scan_end;
	logic [CNT_W-1:0]           cur_ptr;
	logic [nrqs_pkg::ID_W-1:0]  cur_id;
	logic [nrqs_pkg::KEY_W-1:0] cur_key;
	logic                       no_shift;
	logic                       shift_end;

	assign s_tready = (state_q == nrqs_pkg::S_IDLE);
	assign acc      = s_tvalid & s_tready;
	assign in_func  = s_tuser[0];
	assign in_id    = s_tdata[15:0];
	assign in_key   = s_tdata[31:16];

	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	// mode 3 falls back to first come first served
	assign min_mode = (mode_q == nrqs_pkg::MODE_SJF) || (mode_q == nrqs_pkg::MODE_PRIO);
	assign out_free = !m_valid_q || m_tready;
	assign tail     = count_q - CNT_W'(1);

	// running minimum: first entry always taken, strict less keeps the earliest on ties
	assign rd_id    = ram_rdata[nrqs_pkg::ID_W-1:0];
	assign rd_key   = ram_rdata[nrqs_pkg::ENTRY_W-1:nrqs_pkg::ID_W];
	assign take     = (ptr_q == '0) || (rd_key < best_key_q);
	assign cur_ptr  = take ? ptr_q : best_ptr_q;
	assign cur_id   = take ? rd_id : best_id_q;
	assign cur_key  = take ? rd_key : best_key_q;
	assign scan_end = (ptr_q == last_q);
	// removing the tail entry needs no close-up
	assign no_shift  = (cur_ptr == tail);
	assign shift_end = (ptr_q == tail);

	nrqs_ram #(
		.WIDTH (nrqs_pkg::ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr[AW-1:0]),
		.wdata (ram_wdata),
		.raddr (ram_raddr[AW-1:0]),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			nrqs_pkg::S_IDLE: begin
				if (acc) begin
					if (in_func == nrqs_pkg::FUNC_INSERT || empty) begin
						state_d = nrqs_pkg::S_DONE;
					end else begin
						state_d = nrqs_pkg::S_SCAN;
					end
				end
			end
			nrqs_pkg::S_SCAN: begin
				if (scan_end) begin
					state_d = no_shift ? nrqs_pkg::S_DONE : nrqs_pkg::S_SHIFT;
				end
			end
			nrqs_pkg::S_SHIFT: begin
				if (shift_end) begin
					state_d = nrqs_pkg::S_DONE;
				end
			end
			nrqs_pkg::S_DONE: begin
				if (out_free) begin
					state_d = nrqs_pkg::S_IDLE;
				end
			end
			default: state_d = nrqs_pkg::S_IDLE;
		endcase
	end

	// ram control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q;
		ram_wdata = {in_key, in_id};
		ram_raddr = '0;
		case (state_q)
			nrqs_pkg::S_IDLE: begin
				// append at the tail; address 0 is prefetched for a dispatch
				ram_we = acc && (in_func == nrqs_pkg::FUNC_INSERT) && !full;
			end
			nrqs_pkg::S_SCAN: begin
				ram_raddr = scan_end ? cur_ptr + CNT_W'(1) : ptr_q + CNT_W'(1);
			end
			nrqs_pkg::S_SHIFT: begin
				// move entry down one slot while the next one is read
				ram_we    = 1'b1;
				ram_waddr = ptr_q - CNT_W'(1);
				ram_wdata = ram_rdata;
				ram_raddr = ptr_q + CNT_W'(1);
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= nrqs_pkg::S_IDLE;
			count_q   <= '0;
			mode_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			case (state_q)
				nrqs_pkg::S_IDLE: begin
					if (acc && in_func == nrqs_pkg::FUNC_INSERT && !full) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				nrqs_pkg::S_SCAN: begin
					if (scan_end && no_shift) begin
						count_q <= tail;
					end
				end
				nrqs_pkg::S_SHIFT: begin
					if (shift_end) begin
						count_q <= tail;
					end
				end
				default: ;
			endcase
			if (state_q == nrqs_pkg::S_DONE && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			nrqs_pkg::S_IDLE: begin
				if (acc) begin
					ptr_q      <= '0;
					last_q     <= min_mode ? tail : '0;
					best_id_q  <= '0;
					best_key_q <= '0;
					if (in_func == nrqs_pkg::FUNC_INSERT) begin
						status_q <= full ? nrqs_pkg::ST_FULL : nrqs_pkg::ST_OK;
					end else begin
						status_q <= empty ? nrqs_pkg::ST_EMPTY : nrqs_pkg::ST_OK;
					end
				end
			end
			nrqs_pkg::S_SCAN: begin
				best_ptr_q <= cur_ptr;
				best_id_q  <= cur_id;
				best_key_q <= cur_key;
				ptr_q      <= scan_end ? cur_ptr + CNT_W'(1) : ptr_q + CNT_W'(1);
			end
			nrqs_pkg::S_SHIFT: begin
				ptr_q <= ptr_q + CNT_W'(1);
			end
			nrqs_pkg::S_DONE: begin
				if (out_free) begin
					m_tdata_q <= {1'b0, nrqs_pkg::OCC_W'(count_q), best_key_q, best_id_q};
					m_tuser_q <= status_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

FILE: rtl/nrqs_checker.sv
`include "nonpreemptive_ready_queue_scheduler_top_assert.svh"

module nrqs_checker #(
	parameter int QUEUE_DEPTH = nrqs_pkg::QUEUE_DEPTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// stalled result holds
	`NRQS_ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

	// only a good dispatch carries a job
	`NRQS_ASSERT_NOW(a_zero_job, clk, arst_n, m_tvalid && m_tuser != nrqs_pkg::ST_OK,
		m_tdata[31:0] == 32'd0, "job fields set on a failed item")

	// full only when the queue holds every slot
	`NRQS_ASSERT_NOW(a_full_occ, clk, arst_n, m_tvalid && m_tuser == nrqs_pkg::ST_FULL,
		m_tdata[38:32] == nrqs_pkg::OCC_W'(QUEUE_DEPTH), "full reported below depth")

	// empty only when nothing is queued
	`NRQS_ASSERT_NOW(a_empty_occ, clk, arst_n, m_tvalid && m_tuser == nrqs_pkg::ST_EMPTY,
		m_tdata[38:32] == 7'd0, "empty reported with jobs queued")

endmodule

bind nonpreemptive_ready_queue_scheduler_top nrqs_checker #(
	.QUEUE_DEPTH (QUEUE_DEPTH)
) u_nrqs_checker (.*);
